/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the message queue RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that an implication holds: the consequent follows in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/tmq_pkg.sv */
// ---------------------------------------------------------------------------
// tmq_pkg
// Types, constants and command structs of the timed message queue.
// ---------------------------------------------------------------------------
package tmq_pkg;

  localparam int FifoDepth       = 16;
  localparam int DelaySlots      = 8;
  localparam int MaxPayloadBytes = 8;
  localparam int PtrW            = $clog2(FifoDepth);
  localparam int SlotW           = $clog2(DelaySlots);
  localparam int LenW            = 4;
  localparam int RecW            = 8 + LenW + 64 + 64 + 64;

  typedef enum logic [2:0] {
    REQ_ENQ_NOW = 3'd0,
    REQ_ENQ_DUE = 3'd1,
    REQ_PUMP    = 3'd2,
    REQ_EXPIRE  = 3'd3,
    REQ_POP     = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DROPPED = 2'd1,
    ST_QUEUED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ENQ, S_SLOT_WR, S_PUMP_CHK, S_PUMP_PUSH,
    S_EXP_RD, S_EXP_WAIT, S_EXP_CHK, S_POP_RD, S_POP_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic       load;       // capture input item
    logic       push_in;    // push input record into ring
    logic       push_slot;  // push scanned slot into ring
    logic       slot_write; // write input record into free slot
    logic       slot_free;  // free scanned slot
    logic       slot_step;  // advance slot scan
    logic       slot_clear; // restart slot scan
    logic       head_rd;    // read head record
    logic       head_adv;   // drop head record
    logic       count;      // bump moved counter
    logic       set_drop;   // flag drop
    logic       set_queued; // flag queued-now
    logic       set_empty;  // flag empty
    logic       take_rec;   // latch popped record
    logic       out_load;   // publish result
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic free_found;
    logic slot_due;
    logic slot_last;
    logic stale;
    logic out_busy;
  } sts_t;

  function automatic logic [LenW-1:0] clamp_len(input logic [7:0] len);
    clamp_len = (len > 8'(MaxPayloadBytes)) ? LenW'(MaxPayloadBytes) : len[LenW-1:0];
  endfunction

  function automatic logic [63:0] keep_bytes(input logic [63:0] d, input logic [LenW-1:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < len) m[b*8 +: 8] = 8'hFF;
    end
    keep_bytes = d & m;
  endfunction

endpackage

/* rtl/tmq_ram.sv */
// ---------------------------------------------------------------------------
// tmq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tmq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/tmq_ctrl.sv */
// ---------------------------------------------------------------------------
// tmq_ctrl
// Request sequencer: steps each request through the datapath.
// ---------------------------------------------------------------------------
module tmq_ctrl import tmq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_fire,
  input  sts_t   sts,
  output cmd_t   cmd,
  output logic   busy
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_fire) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (sts.req)
          REQ_ENQ_NOW: state_nxt = S_ENQ;
          REQ_ENQ_DUE: state_nxt = sts.free_found ? S_SLOT_WR : S_ENQ;
          REQ_PUMP:    state_nxt = S_PUMP_CHK;
          REQ_EXPIRE:  state_nxt = S_EXP_RD;
          REQ_POP:     state_nxt = sts.empty ? S_OUT : S_POP_RD;
          default:     state_nxt = S_OUT;
        endcase
      end
      S_ENQ, S_SLOT_WR: state_nxt = S_OUT;
      S_PUMP_CHK:  state_nxt = sts.slot_due ? S_PUMP_PUSH : (sts.slot_last ? S_OUT : S_PUMP_CHK);
      S_PUMP_PUSH: state_nxt = sts.slot_last ? S_OUT : S_PUMP_CHK;
      S_EXP_RD:    state_nxt = sts.empty ? S_OUT : S_EXP_WAIT;
      S_EXP_WAIT:  state_nxt = S_EXP_CHK;
      S_EXP_CHK:   state_nxt = sts.stale ? S_EXP_RD : S_OUT;
      S_POP_RD:    state_nxt = S_POP_WAIT;
      S_POP_WAIT:  state_nxt = S_OUT;
      S_OUT:       if (!sts.out_busy) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:     cmd.load = in_fire;
      S_DISPATCH: begin
        cmd.slot_clear = 1'b1;
        if (sts.req == REQ_POP) begin
          cmd.set_empty = sts.empty;
          cmd.head_rd   = 1'b1;
        end
      end
      S_ENQ: begin
        cmd.push_in    = !sts.full;
        cmd.set_drop   = sts.full;
        cmd.set_queued = (sts.req == REQ_ENQ_DUE) && !sts.full;
      end
      S_SLOT_WR:  cmd.slot_write = 1'b1;
      S_PUMP_CHK: cmd.slot_step = !sts.slot_due;
      S_PUMP_PUSH: begin
        cmd.push_slot = !sts.full;
        cmd.set_drop  = sts.full;
        cmd.slot_free = 1'b1;
        cmd.count     = 1'b1;
        cmd.slot_step = 1'b1;
      end
      S_EXP_RD:   cmd.head_rd = 1'b1;
      S_EXP_CHK: begin
        cmd.head_adv = sts.stale;
        cmd.count    = sts.stale;
      end
      S_POP_RD:   cmd.head_rd = 1'b1;
      S_POP_WAIT: begin
        cmd.take_rec = 1'b1;
        cmd.head_adv = 1'b1;
      end
      S_OUT:      cmd.out_load = !sts.out_busy;
      default:    cmd = '0;
    endcase
  end
endmodule

/* rtl/tmq_dp.sv */
// ---------------------------------------------------------------------------
// tmq_dp
// Datapath: ring FIFO memory, delay slots, and result assembly.
// ---------------------------------------------------------------------------
module tmq_dp import tmq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  logic [2:0]   req_type,
  input  logic [63:0]  now_time,
  input  logic [63:0]  due_time,
  input  logic [7:0]   opcode,
  input  logic [63:0]  payload,
  input  logic [7:0]   payload_len,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [RecW+2+5-1:0] out_word
);
  logic [2:0]       req_r;
  logic [63:0]      now_r, due_r, pay_r, limit_r;
  logic [7:0]       op_r;
  logic [LenW-1:0]  len_r;
  logic [PtrW-1:0]  head_r, tail_r;
  logic [DelaySlots-1:0] used_r;
  logic [SlotW-1:0] scan_r;
  logic [4:0]       moved_r;
  logic [1:0]       status_r;
  logic             out_valid_r;
  logic [RecW-1:0]  rec_r;
  logic [7:0]       s_op    [DelaySlots];
  logic [LenW-1:0]  s_len   [DelaySlots];
  logic [63:0]      s_pay   [DelaySlots];
  logic [63:0]      s_due   [DelaySlots];
  logic [SlotW-1:0] free_idx;
  logic             free_found;
  logic [RecW-1:0]  ram_wdata, ram_rdata;
  logic             ram_we;
  logic [PtrW-1:0]  tail_nxt;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = DelaySlots-1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
  end

  assign tail_nxt = tail_r + PtrW'(1);
  assign ram_we   = cmd.push_in | cmd.push_slot;
  // record layout: op, len, payload, enq time, due time (due = enq = now)
  assign ram_wdata = cmd.push_slot ?
    {s_op[scan_r], s_len[scan_r], s_pay[scan_r], now_r, now_r} :
    {op_r, len_r, pay_r, now_r, now_r};

  tmq_ram #(.Width(RecW), .Depth(FifoDepth)) u_ring (
    .clk(clk), .we(ram_we), .waddr(tail_r), .wdata(ram_wdata),
    .raddr(head_r), .rdata(ram_rdata)
  );

  assign sts.req        = req_t'(req_r);
  assign sts.full       = (tail_nxt == head_r);
  assign sts.empty      = (tail_r == head_r);
  assign sts.free_found = free_found;
  assign sts.slot_due   = used_r[scan_r] && (now_r >= s_due[scan_r]);
  assign sts.slot_last  = (scan_r == SlotW'(DelaySlots-1));
  assign sts.stale      = (now_r - ram_rdata[127:64]) > limit_r;
  assign sts.out_busy   = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; tail_r <= '0; used_r <= '0; scan_r <= '0;
      limit_r <= '1; out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (ram_we) tail_r <= tail_nxt;
      if (cmd.head_adv) head_r <= head_r + PtrW'(1);
      if (cmd.slot_clear) scan_r <= '0;
      else if (cmd.slot_step) scan_r <= scan_r + SlotW'(1);
      if (cmd.slot_write) used_r[free_idx] <= 1'b1;
      if (cmd.slot_free)  used_r[scan_r]   <= 1'b0;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_type; now_r <= now_time; due_r <= due_time; op_r <= opcode;
      len_r <= clamp_len(payload_len);
      pay_r <= keep_bytes(payload, clamp_len(payload_len));
      moved_r <= '0; status_r <= ST_DONE; rec_r <= '0;
    end else begin
      if (cmd.count && moved_r != 5'd31) moved_r <= moved_r + 5'd1;
      if (cmd.set_drop)   status_r <= ST_DROPPED;
      if (cmd.set_queued) status_r <= ST_QUEUED;
      if (cmd.set_empty)  status_r <= ST_EMPTY;
      if (cmd.take_rec)   rec_r <= ram_rdata;
    end
    if (cmd.slot_write) begin
      s_op[free_idx] <= op_r; s_len[free_idx] <= len_r;
      s_pay[free_idx] <= pay_r; s_due[free_idx] <= due_r;
    end
    // result order from the low end: status, count, op, payload, len, enq, due
    if (cmd.out_load) out_word <= {rec_r[63:0], rec_r[127:64], rec_r[195:192],
                                   rec_r[191:128], rec_r[203:196], moved_r, status_r};
  end

  assign out_valid = out_valid_r;
endmodule

/* rtl/timed_message_queue_top.sv */
// Timed message queue: one request at a time, one result per request.
// An enqueue writes the ring or a free delay slot; a pump scans every delay slot
// in order and moves due entries to the ring; an expire drops stale head records
// one by one until the head is fresh or the ring is empty. The next request is
// taken once the result register loads; a stalled result holds the sequencer.
// Reset (rst_n low, synchronous): ring empty, delay slots free, stale_limit all ones.
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// timed_message_queue_top
// Ring FIFO with delay slots, pump, expire and pop requests.
// ---------------------------------------------------------------------------
module timed_message_queue_top import tmq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [63:0]   cfg_wdata,      // stale_limit
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [2:0] req_type, [66:3] now_time, [130:67] due_time, [138:131] opcode,
  // [202:139] payload, [210:203] payload_len, [215:211] zero
  input  logic [215:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [1:0] status, [6:2] moved_count, [14:7] rec_opcode, [78:15] rec_payload,
  // [82:79] rec_len, [146:83] rec_enq_time, [210:147] rec_due_time,
  // [215:211] zero
  output logic [215:0]  m_axis_tdata
);
  cmd_t cmd;
  sts_t sts;
  logic busy;
  logic in_fire;
  logic [RecW+6:0] word;

  // accept only when the sequencer is idle
  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  tmq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .sts(sts), .cmd(cmd), .busy(busy)
  );

  tmq_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .req_type(s_axis_tdata[2:0]), .now_time(s_axis_tdata[66:3]),
    .due_time(s_axis_tdata[130:67]), .opcode(s_axis_tdata[138:131]),
    .payload(s_axis_tdata[202:139]), .payload_len(s_axis_tdata[210:203]),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .out_word(word)
  );

  // word packs status, moved count and record (op, payload, len, enq, due)
  assign m_axis_tdata = {5'd0, word};

  // a ring push and a result publish never coincide
  `ASSERT_CLK(a_push_not_out, clk, rst_n, !((cmd.push_in || cmd.push_slot) && cmd.out_load))
  // no input is taken while a request is in flight
  `ASSERT_CLK(a_no_accept_busy, clk, rst_n, !(busy && s_axis_tready))
  // publishing a result raises the output valid
  `ASSERT_NEXT(a_out_valid, clk, rst_n, cmd.out_load, m_axis_tvalid)
endmodule

/* sim/timed_message_queue_top_test.sv */
// ---------------------------------------------------------------------------
// timed_message_queue_top_test
// Drives enqueue, delayed enqueue, pump, expire and pop requests into the
// message queue, predicts every result from a behavioral copy of the ring
// and delay slots, and compares each result transfer field by field.
// ---------------------------------------------------------------------------
module timed_message_queue_top_test;
  import tmq_pkg::*;

  // Expected result of one request
  typedef struct {
    status_t     status;
    logic [4:0]  moved;
    logic [7:0]  opcode;
    logic [63:0] payload;
    logic [3:0]  len;
    logic [63:0] enq_time;
    logic [63:0] due_time;
  } qresult_t;

  // Behavioral copy of the queue plus the store of pending results
  class queue_scoreboard;
    logic [63:0] stale_limit;
    int unsigned head, tail;
    logic [7:0]  f_op[FifoDepth];
    logic [3:0]  f_len[FifoDepth];
    logic [63:0] f_data[FifoDepth], f_enq[FifoDepth], f_due[FifoDepth];
    bit          s_used[DelaySlots];
    logic [7:0]  s_op[DelaySlots];
    logic [3:0]  s_len[DelaySlots];
    logic [63:0] s_data[DelaySlots], s_due[DelaySlots];
    qresult_t    pending[$];
    int          errors;

    function void clear();
      stale_limit = '1;
      head = 0;
      tail = 0;
      foreach (s_used[i]) s_used[i] = 0;
      pending.delete();
    endfunction

    function int unsigned fill();
      return (tail + FifoDepth - head) % FifoDepth;
    endfunction

    function int unsigned free_slots();
      int unsigned n;
      n = 0;
      foreach (s_used[i]) if (!s_used[i]) n++;
      return n;
    endfunction

    function logic [63:0] mask_bytes(logic [63:0] d, logic [3:0] len);
      logic [63:0] r;
      r = '0;
      for (int b = 0; b < 8; b++) if (b < len) r[b*8 +: 8] = d[b*8 +: 8];
      return r;
    endfunction

    function bit ring_push(logic [63:0] now, logic [7:0] op, logic [63:0] d,
                           logic [3:0] len);
      if ((tail + 1) % FifoDepth == head) return 0;
      f_op[tail] = op;
      f_len[tail] = len;
      f_data[tail] = mask_bytes(d, len);
      f_enq[tail] = now;
      f_due[tail] = now;
      tail = (tail + 1) % FifoDepth;
      return 1;
    endfunction

    // Note an accepted request: advance the copy and queue its result
    function void note_request(logic [215:0] item);
      qresult_t    r;
      logic [2:0]  req;
      logic [63:0] now, due, data;
      logic [7:0]  op, raw_len;
      logic [3:0]  len;
      int          k;
      req = item[2:0];
      now = item[66:3];
      due = item[130:67];
      op = item[138:131];
      data = item[202:139];
      raw_len = item[210:203];
      len = (raw_len > 8'(MaxPayloadBytes)) ? 4'(MaxPayloadBytes) : raw_len[3:0];
      r = '{ST_DONE, 5'd0, 8'd0, 64'd0, 4'd0, 64'd0, 64'd0};
      case (req)
        REQ_ENQ_NOW: begin
          if (!ring_push(now, op, data, len)) r.status = ST_DROPPED;
        end
        REQ_ENQ_DUE: begin
          k = -1;
          for (int i = 0; i < DelaySlots; i++) if (k < 0 && !s_used[i]) k = i;
          if (k >= 0) begin
            s_used[k] = 1;
            s_op[k] = op;
            s_len[k] = len;
            s_data[k] = mask_bytes(data, len);
            s_due[k] = due;
          end else begin
            r.status = ring_push(now, op, data, len) ? ST_QUEUED : ST_DROPPED;
          end
        end
        REQ_PUMP: begin
          for (int i = 0; i < DelaySlots; i++) begin
            if (s_used[i] && now >= s_due[i]) begin
              if (!ring_push(now, s_op[i], s_data[i], s_len[i])) r.status = ST_DROPPED;
              s_used[i] = 0;
              if (r.moved < 31) r.moved++;
            end
          end
        end
        REQ_EXPIRE: begin
          while (head != tail && (now - f_enq[head]) > stale_limit) begin
            head = (head + 1) % FifoDepth;
            if (r.moved < 31) r.moved++;
          end
        end
        REQ_POP: begin
          if (head == tail) begin
            r.status = ST_EMPTY;
          end else begin
            r.opcode = f_op[head];
            r.payload = f_data[head];
            r.len = f_len[head];
            r.enq_time = f_enq[head];
            r.due_time = f_due[head];
            head = (head + 1) % FifoDepth;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Check one result transfer against the oldest expectation
    function void check_result(logic [215:0] d);
      qresult_t e;
      if (pending.size() == 0) begin
        $error("result: expected none, got %0h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare("status", e.status, d[1:0]);
      compare("moved_count", e.moved, d[6:2]);
      compare("rec_opcode", e.opcode, d[14:7]);
      compare("rec_payload", e.payload, d[78:15]);
      compare("rec_len", e.len, d[82:79]);
      compare("rec_enq_time", e.enq_time, d[146:83]);
      compare("rec_due_time", e.due_time, d[210:147]);
      compare("pad", 64'd0, d[215:211]);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_we = 0;
  logic [63:0]  cfg_wdata = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [215:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [215:0] out_tdata;

  queue_scoreboard sb = new();
  longint      cycle = 0;
  logic [63:0] clock_now = 64'd1000;

  always #6 clk = ~clk;

  timed_message_queue_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(in_tvalid), .s_axis_tready(in_tready), .s_axis_tdata(in_tdata),
    .m_axis_tvalid(out_tvalid), .m_axis_tready(out_tready), .m_axis_tdata(out_tdata)
  );

  // Mostly short gaps, sometimes long ones, sometimes none at all
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Watchdog: a run that never finishes is ended and reported as a mismatch
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 1000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random back-pressure, check each transfer
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      g = gap_len();
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) begin
          @(posedge clk);
        end
      end
      out_tready <= 1;
    end
  end

  // Present one request and hold it until the transfer
  task automatic send_request(req_t req, logic [63:0] now, logic [63:0] due,
                              logic [7:0] op, logic [63:0] data, logic [7:0] len);
    int g;
    g = gap_len();
    repeat (g + 1) @(posedge clk);
    in_tdata <= {5'd0, len, data, op, due, now, req};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request({5'd0, len, data, op, due, now, req});
    in_tvalid <= 0;
  endtask

  // Raw item, used for the unused request codes
  task automatic send_raw(logic [215:0] item);
    @(posedge clk);
    in_tdata <= item;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(item);
    in_tvalid <= 0;
  endtask

  // Wait until every expected result has arrived, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_limit(logic [63:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.stale_limit = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // One random request; mostly small time steps so due and stale logic bites
  task automatic random_request();
    int          p;
    req_t        r;
    logic [63:0] due;
    logic [7:0]  len;
    p = $urandom_range(0, 99);
    clock_now = clock_now + $urandom_range(0, 20);
    if ($urandom_range(0, 49) == 0) clock_now = rand64();
    r = (p < 30) ? REQ_ENQ_NOW : (p < 50) ? REQ_ENQ_DUE : (p < 65) ? REQ_PUMP :
        (p < 75) ? REQ_EXPIRE : REQ_POP;
    due = ($urandom_range(0, 9) == 0) ? rand64() : clock_now + $urandom_range(0, 60);
    len = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 9));
    send_request(r, clock_now, due, 8'($urandom()), rand64(), len);
  endtask

  initial begin
    logic [63:0] limits[4];
    limits = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd30, 64'd200};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    sb.clear();

    // Directed: empty pop, field extremes, fill ring to dropping
    send_request(REQ_POP, 64'd0, 64'd0, 8'd0, 64'd0, 8'd0);
    send_request(REQ_ENQ_NOW, '1, '1, 8'hFF, '1, 8'hFF);
    send_request(REQ_ENQ_NOW, 64'd0, 64'd0, 8'h00, '1, 8'd3);
    send_request(REQ_ENQ_NOW, 64'd5, 64'd0, 8'h5A, '1, 8'd0);
    for (int i = 0; i < 14; i++)
      send_request(REQ_ENQ_NOW, 64'd10 + i, 64'd0, 8'(i), rand64(), 8'd8);
    // Delay slots: fill all eight, ninth is queued now or dropped
    for (int i = 0; i < 9; i++)
      send_request(REQ_ENQ_DUE, 64'd20, 64'd50 + i, 8'(i), rand64(), 8'd4);
    send_request(REQ_PUMP, 64'd100, 64'd0, 8'd0, 64'd0, 8'd0);
    send_raw({5'd0, 8'hFF, 64'hFFFF, 8'hFF, 64'd0, 64'd0, 3'd5});
    send_raw({5'd0, 8'd0, 64'd0, 8'd0, 64'd0, 64'd0, 3'd7});
    send_request(REQ_EXPIRE, 64'd0, 64'd0, 8'd0, 64'd0, 8'd0);
    drain();
    write_limit(64'd0);
    send_request(REQ_EXPIRE, 64'd100, 64'd0, 8'd0, 64'd0, 8'd0);
    send_request(REQ_POP, 64'd100, 64'd0, 8'd0, 64'd0, 8'd0);
    drain();

    // Random phases across several stale limits
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      for (int n = 0; n < 280; n++) random_request();
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
